[rtl/gpm_pkg.sv]
// Package for the gate pose matcher: payload structs, op codes, config indices, state enum.
// No dependencies.
package gpm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_GATE = 2'd0,
    OP_LOAD_ATT  = 2'd1,
    OP_LOAD_POS  = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  localparam logic [2:0] CFG_EXT0   = 3'd0;
  localparam logic [2:0] CFG_EXT1   = 3'd1;
  localparam logic [2:0] CFG_EXT2   = 3'd2;
  localparam logic [2:0] CFG_GATES  = 3'd3;
  localparam logic [2:0] CFG_RADIUS = 3'd4;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         slot;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         gate_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT,
    ST_ATT,
    ST_SCAN,
    ST_DIST,
    ST_DONE
  } state_t;

endpackage

[rtl/gate_pose_match.sv]
// Gate pose matcher top level: one shared multiplier steps through the
// extrinsic and attitude products, then scans the gate table.
// Depends on gpm_pkg.
// Loads: written at the input transfer; the block stays in ST_IDLE, ready for more.
// Query: 9 multiply steps for the extrinsic, 9 for the attitude, then per scanned
// slot a table read in ST_SCAN, then three squarings and a compare in ST_DIST.
// With no match all of the first min(gates_in_use, GATES) slots are scanned (an
// earlier match ends the scan sooner), paced by the single shared multiplier;
// input is ready again once the result has transferred.
// Reset (synchronous, rst_n low) restores registers to their reset values,
// identity attitude and zero position; the gate table is not cleared.
module gate_pose_match
  import gpm_pkg::*;
#(
  parameter int GATES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = (GATES > 1) ? $clog2(GATES) : 1;

  state_t state_r, state_nxt;

  logic [63:0] ext_r [3];
  logic [6:0]  gates_in_use_r;
  logic [31:0] radius_r;
  logic signed [31:0] att_r [3][3];
  logic signed [31:0] pos_r [3];
  logic [95:0] table_mem [GATES];
  logic [95:0] rd_r;

  logic signed [31:0] t_r [3];
  logic signed [31:0] c_r [3];
  logic signed [63:0] g_r [3];
  logic signed [63:0] acc_r;
  logic [1:0] i_r, j_r;
  logic [10:0] k_r;
  logic [AW-1:0] k_idx_r;
  logic [10:0] limit;
  logic signed [63:0] d_r [3];
  logic far_r;
  logic far_now;
  logic [66:0] sum_r;
  out_item_t res_r;
  logic out_valid_r;

  // Shared multiplier operands.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [15:0] e_coef;
  logic signed [15:0] e_off;
  logic signed [63:0] ext_acc;
  logic signed [63:0] rd_g [3];

  assign limit = ({4'd0, gates_in_use_r} < 11'(GATES)) ? {4'd0, gates_in_use_r} : 11'(GATES);
  assign e_coef = ext_r[i_r][16*j_r +: 16];
  assign e_off  = ext_r[i_r][63:48];

  always_comb begin
    mul_a = e_coef;
    mul_b = t_r[j_r];
    unique case (state_r)
      ST_ATT: begin
        mul_a = att_r[i_r][j_r];
        mul_b = c_r[j_r];
      end
      ST_DIST: begin
        mul_a = d_r[j_r][31:0];
        mul_b = d_r[j_r][31:0];
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign ext_acc = (acc_r + prod) >>> 14;

  assign rd_g[0] = 64'(signed'(rd_r[95:64])) - g_r[0];
  assign rd_g[1] = 64'(signed'(rd_r[63:32])) - g_r[1];
  assign rd_g[2] = 64'(signed'(rd_r[31:0])) - g_r[2];

  // A component difference of 2^24 or more can never match.
  always_comb begin
    far_now = 1'b0;
    for (int r = 0; r < 3; r++)
      if (rd_g[r] >= 64'sd16777216 || rd_g[r] <= -64'sd16777216) far_now = 1'b1;
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready && in_data.op == OP_QUERY) state_nxt = ST_EXT;
      ST_EXT:  if (i_r == 2'd2 && j_r == 2'd2) state_nxt = ST_ATT;
      ST_ATT:  if (i_r == 2'd2 && j_r == 2'd2) state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = (k_r >= limit) ? ST_DONE : ST_DIST;
      ST_DIST: begin
        if (j_r == 2'd3) state_nxt = ST_SCAN;
        if (j_r == 2'd3 && !far_r && (sum_r >> 16) < 67'(radius_r)) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Table memory: written by gate loads, read one slot per scan step.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.op == OP_LOAD_GATE && 11'(in_data.slot) < 11'(GATES))
      table_mem[AW'(in_data.slot)] <= {in_data.vec_x, in_data.vec_y, in_data.vec_z};
    rd_r <= table_mem[k_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        ext_r[r] <= '0;
        pos_r[r] <= '0;
        for (int q = 0; q < 3; q++) att_r[r][q] <= (r == q) ? ONE_Q16 : 32'sd0;
      end
      gates_in_use_r <= '0;
      radius_r <= 32'd65536;
      i_r <= '0; j_r <= '0; k_r <= '0; k_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_EXT0:   ext_r[0] <= cfg_data;
          CFG_EXT1:   ext_r[1] <= cfg_data;
          CFG_EXT2:   ext_r[2] <= cfg_data;
          CFG_GATES:  gates_in_use_r <= cfg_data[6:0];
          CFG_RADIUS: radius_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          i_r <= '0; j_r <= '0; acc_r <= '0;
          if (in_valid && in_ready) begin
            t_r[0] <= in_data.vec_x; t_r[1] <= in_data.vec_y; t_r[2] <= in_data.vec_z;
            if (in_data.op == OP_LOAD_ATT && in_data.slot < 6'd3) begin
              att_r[in_data.slot[1:0]][0] <= in_data.vec_x;
              att_r[in_data.slot[1:0]][1] <= in_data.vec_y;
              att_r[in_data.slot[1:0]][2] <= in_data.vec_z;
            end
            if (in_data.op == OP_LOAD_POS) begin
              pos_r[0] <= in_data.vec_x; pos_r[1] <= in_data.vec_y; pos_r[2] <= in_data.vec_z;
            end
          end
        end
        ST_EXT: begin
          if (j_r == 2'd2) begin
            c_r[i_r] <= sat32(ext_acc + 64'(e_off) * 64'sd16);
            acc_r <= '0; j_r <= '0; i_r <= (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
          end else begin
            acc_r <= acc_r + prod; j_r <= j_r + 2'd1;
          end
        end
        ST_ATT: begin
          if (j_r == 2'd2) begin
            g_r[i_r] <= acc_r + (prod >>> 16) + 64'(pos_r[i_r]);
            acc_r <= '0; j_r <= '0; i_r <= (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
          end else begin
            acc_r <= acc_r + (prod >>> 16); j_r <= j_r + 2'd1;
          end
          k_r <= '0; k_idx_r <= '0;
        end
        ST_SCAN: begin
          // rd_r holds slot k_r here (address k_idx_r was set in ST_ATT or the previous ST_SCAN).
          for (int r = 0; r < 3; r++) d_r[r] <= rd_g[r];
          far_r <= far_now;
          sum_r <= '0; j_r <= '0;
          k_r <= k_r + 11'd1;
          k_idx_r <= AW'(k_r + 11'd1);
        end
        ST_DIST: begin
          if (j_r != 2'd3) begin
            sum_r <= sum_r + 67'(unsigned'(prod)); j_r <= j_r + 2'd1;
          end
        end
        default: ;
      endcase
      if (state_r == ST_SCAN && k_r >= limit) begin
        res_r <= '0; out_valid_r <= 1'b1;
      end
      if (state_r == ST_DIST && j_r == 2'd3 && !far_r && (sum_r >> 16) < 67'(radius_r)) begin
        res_r.found <= 1'b1;
        res_r.gate_slot <= 6'(k_r - 11'd1);
        res_r.pos_x <= sat32(d_r[0] + 64'(pos_r[0]));
        res_r.pos_y <= sat32(d_r[1] + 64'(pos_r[1]));
        res_r.pos_z <= sat32(d_r[2] + 64'(pos_r[2]));
        out_valid_r <= 1'b1;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_result_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> out_valid_r) else $error("done without result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for gate_pose_match: loads, queries and register settings.
// Depends on gpm_pkg and the gate_pose_match RTL.
`timescale 1ns / 100ps

module tb_top;
  import gpm_pkg::*;

  localparam int NGATES = 64;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  gate_pose_match #(.GATES(NGATES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state.
  logic signed [31:0] gate_pos [NGATES][3];
  bit                 gate_written [NGATES];
  logic signed [31:0] att_row [3][3];
  logic signed [31:0] body_pos [3];
  logic [63:0]        ext_row [3];
  logic [6:0]         scan_count;
  logic [31:0]        radius_sq;

  in_item_t  pending_items [$];
  out_item_t expected_fixes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  bit in_taken = 1'b0;
  int mismatches = 0;
  int fixes_seen = 0;
  int queries_sent = 0;
  int quiet_cycles = 0;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) att_row[i][j] = (i == j) ? ONE_Q16 : 32'sd0;
      body_pos[i] = '0;
      ext_row[i] = '0;
    end
    foreach (gate_written[k]) gate_written[k] = 1'b0;
    scan_count = '0;
    radius_sq = 32'd65536;
  endfunction

  function automatic void write_reg_model(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_EXT0, CFG_EXT1, CFG_EXT2: ext_row[idx] = val;
      CFG_GATES: scan_count = val[6:0];
      CFG_RADIUS: radius_sq = val[31:0];
      default: ;
    endcase
  endfunction

  // Applies one accepted item; queries append the expected position fix.
  function automatic void predict_fix(in_item_t it);
    logic signed [63:0] t [3];
    logic signed [63:0] c [3];
    logic signed [63:0] g [3];
    logic signed [63:0] d [3];
    logic signed [63:0] acc;
    logic [63:0]        dist_sq;
    bit                 near;
    int                 lim;
    out_item_t          fix;
    t[0] = it.vec_x; t[1] = it.vec_y; t[2] = it.vec_z;
    case (op_t'(it.op))
      OP_LOAD_GATE: begin
        for (int i = 0; i < 3; i++) gate_pos[it.slot][i] = t[i][31:0];
        gate_written[it.slot] = 1'b1;
      end
      OP_LOAD_ATT: begin
        if (it.slot < 3) for (int i = 0; i < 3; i++) att_row[it.slot][i] = t[i][31:0];
      end
      OP_LOAD_POS: begin
        for (int i = 0; i < 3; i++) body_pos[i] = t[i][31:0];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += 64'(signed'(ext_row[i][16*j +: 16])) * t[j];
          acc = (acc >>> 14) + 64'(signed'(ext_row[i][63:48])) * 16;
          c[i] = sat32(acc);
        end
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += (64'(att_row[i][j]) * c[j]) >>> 16;
          g[i] = acc + body_pos[i];
        end
        fix = '0;
        lim = (scan_count > NGATES) ? NGATES : scan_count;
        for (int k = 0; k < lim; k++) begin
          near = 1'b1;
          dist_sq = 0;
          for (int i = 0; i < 3; i++) begin
            d[i] = 64'(gate_pos[k][i]) - g[i];
            if (d[i] >= 64'sd16777216 || d[i] <= -64'sd16777216) near = 1'b0;
          end
          if (!near) continue;
          for (int i = 0; i < 3; i++) dist_sq += 64'(d[i] * d[i]);
          if (dist_sq < ({32'd0, radius_sq} << 16)) begin
            fix.found = 1'b1;
            fix.gate_slot = k[5:0];
            fix.pos_x = sat32(d[0] + body_pos[0]);
            fix.pos_y = sat32(d[1] + body_pos[1]);
            fix.pos_z = sat32(d[2] + body_pos[2]);
            break;
          end
        end
        expected_fixes.insert(expected_fixes.size(), fix);
      end
    endcase
  endfunction

  // Driver: inputs move on the falling edge, after a transfer seen at the rising edge.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Receiver hold: the stall cycles are counted here.
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      recv_hold <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
    end
  end

  // Monitor: input transfers feed the predictor, results compared at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_fix(in_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      fixes_seen <= fixes_seen + 1;
      if (expected_fixes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer %p", out_data);
      end else if (out_data !== expected_fixes[0]) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("mismatch: expected %p actual %p", expected_fixes[0], out_data);
        void'(expected_fixes.pop_front());
      end else begin
        void'(expected_fixes.pop_front());
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    write_reg_model(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is sent and every result is in, then lets the block settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_fixes.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic void add_pending(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  function automatic logic signed [31:0] small_q16(int range_q16);
    return $signed($urandom_range(2 * range_q16)) - range_q16;
  endfunction

  function automatic in_item_t make_item(op_t op, int slot, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z);
    in_item_t it;
    it.op = op; it.slot = slot[5:0]; it.vec_x = x; it.vec_y = y; it.vec_z = z;
    if (op == OP_QUERY) queries_sent++;
    return it;
  endfunction

  // A Q2.14 near-identity extrinsic row with a small offset.
  function automatic logic [63:0] ext_near(int row);
    logic [63:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = ((j == row) ? 16'sd16384 : 16'sd0) + 16'($signed($urandom_range(400)) - 200);
    r[63:48] = 16'($signed($urandom_range(8192)) - 4096);
    return r;
  endfunction

  task automatic fill_gates(int n);
    for (int k = 0; k < n; k++)
      add_pending(make_item(OP_LOAD_GATE, k, small_q16(20 << 16),
                            small_q16(20 << 16), small_q16(20 << 16)));
  endtask

  task automatic random_phase(int n, int ngates);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        // Query drawn from a range just wider than that of the stored gates.
        add_pending(make_item(OP_QUERY, $urandom_range(63),
          small_q16(21 << 16), small_q16(21 << 16), small_q16(21 << 16)));
      end else if (r < 65) begin
        add_pending(make_item(OP_QUERY, $urandom_range(63),
          rand_word(), rand_word(), rand_word()));
      end else if (r < 78) begin
        add_pending(make_item(OP_LOAD_GATE, $urandom_range(ngates - 1),
          small_q16(20 << 16), small_q16(20 << 16), small_q16(20 << 16)));
      end else if (r < 82) begin
        add_pending(make_item(OP_LOAD_GATE, $urandom_range(ngates - 1),
          rand_word(), rand_word(), rand_word()));
      end else if (r < 90) begin
        add_pending(make_item(OP_LOAD_ATT, $urandom_range(3),
          small_q16(1 << 16), small_q16(1 << 16), small_q16(1 << 16)));
      end else if (r < 92) begin
        add_pending(make_item(OP_LOAD_ATT, $urandom_range(63),
          rand_word(), rand_word(), rand_word()));
      end else if (r < 98) begin
        add_pending(make_item(OP_LOAD_POS, $urandom_range(63),
          small_q16(5 << 16), small_q16(5 << 16), small_q16(5 << 16)));
      end else begin
        add_pending(make_item(OP_LOAD_POS, $urandom_range(63),
          rand_word(), rand_word(), rand_word()));
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, then extremes.
    add_pending(make_item(OP_QUERY, 0, 32'sd0, 32'sd0, 32'sd0));
    drain();
    write_reg(CFG_EXT0, {16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    write_reg(CFG_EXT1, {16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    write_reg(CFG_EXT2, {16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    write_reg(CFG_GATES, 7'd4);
    write_reg(CFG_RADIUS, 32'd65536);
    add_pending(make_item(OP_LOAD_GATE, 0, 32'sh7fffffff, 32'sh80000000, 32'sd0));
    add_pending(make_item(OP_LOAD_GATE, 1, 32'sd65536, 32'sd0, 32'sd0));
    add_pending(make_item(OP_LOAD_GATE, 2, 32'sd65536, 32'sd0, 32'sd0));
    add_pending(make_item(OP_LOAD_GATE, 3, -32'sd65536, 32'sd0, 32'sd0));
    add_pending(make_item(OP_LOAD_GATE, 63, 32'sd1, -32'sd1, 32'sd2));
    add_pending(make_item(OP_QUERY, 63, 32'sd65536, 32'sd0, 32'sd0));
    add_pending(make_item(OP_QUERY, 5, 32'sh7fffffff, 32'sh80000000, 32'sd0));
    add_pending(make_item(OP_QUERY, 0, -32'sd65536, 32'sd40000, 32'sd0));
    // Attitude row out of range is ignored; position load ignores slot.
    add_pending(make_item(OP_LOAD_ATT, 3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    add_pending(make_item(OP_LOAD_ATT, 2, 32'sd0, 32'sd0, -32'sd65536));
    add_pending(make_item(OP_LOAD_POS, 41, 32'sh7fffffff, 32'sh80000000, 32'sd0));
    add_pending(make_item(OP_QUERY, 0, 32'sd0, 32'sd0, 32'sd0));
    add_pending(make_item(OP_LOAD_POS, 0, 32'sd0, 32'sd0, 32'sd0));
    add_pending(make_item(OP_LOAD_ATT, 2, 32'sd0, 32'sd0, 32'sd65536));
    add_pending(make_item(OP_QUERY, 0, 32'sd70000, 32'sd0, 32'sd0));
    drain();
    // Every slot written, then scan count above the table size and radius extremes.
    fill_gates(NGATES);
    drain();
    write_reg(CFG_GATES, 7'd127);
    write_reg(CFG_RADIUS, 32'hffffffff);
    write_reg(3'd6, 64'hffffffffffffffff);
    add_pending(make_item(OP_QUERY, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    add_pending(make_item(OP_QUERY, 0, 32'sd100000, 32'sd0, 32'sd0));
    drain();
    write_reg(CFG_RADIUS, 32'd0);
    add_pending(make_item(OP_QUERY, 0, 32'sd0, 32'sd0, 32'sd0));
    drain();
    write_reg(CFG_EXT0, 64'hffffffffffffffff);
    write_reg(CFG_EXT1, 64'h7fff7fff7fff7fff);
    write_reg(CFG_EXT2, 64'h8000800080008000);
    add_pending(make_item(OP_QUERY, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    add_pending(make_item(OP_QUERY, 0, 32'sh80000000, 32'sh7fffffff, 32'sd1));
    drain();

    // Random phases with different settings and idling.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 32 : 0;
      for (int i = 0; i < 3; i++) write_reg(3'(i), ext_near(i));
      write_reg(CFG_GATES, (ph == 0) ? 7'd16 : (ph == 1) ? 7'd8 : 7'd64);
      write_reg(CFG_RADIUS, $urandom_range(1 << 20, 1 << 16));
      random_phase(160, NGATES);
      if (ph == 2) begin
        // Long receiver hold while the sender keeps offering items.
        while (pending_items.size() > 120) @(posedge clk);
        @(negedge clk);
        hold_req <= 1'b1;
      end
      drain();
    end

    $display("covered %0d queries, %0d results, all ops, idling and register extremes",
             queries_sent, fixes_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
